### rtl/aav_pkg.sv
// ----------------------------------------------------------------------------
// aav_pkg
// Shared widths, types and the CORDIC arctangent table of the axis-angle
// vector rotator.
// ----------------------------------------------------------------------------
package aav_pkg;

    // Field widths
    localparam int VEC_WIDTH    = 32;
    localparam int COEF_WIDTH   = 18;
    localparam int CORDIC_STEPS = 16;
    localparam int AXIS_W       = 16;
    localparam int ANGLE_W      = 16;

    // Internal fixed point: Q30 in a signed word with headroom
    localparam int Q_FRAC    = 30;
    localparam int Q_W       = 34;
    localparam int COEF_FRAC = COEF_WIDTH - 2;
    localparam int COEF_SH   = Q_FRAC - COEF_FRAC;
    localparam int COEF_RND  = (2 ** COEF_SH) / 2;

    // Vector datapath widths
    localparam int PROD_W = VEC_WIDTH + COEF_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RES_W  = SUM_W - COEF_FRAC;

    // Axis normalization
    localparam int N2_W       = 2 * AXIS_W;
    localparam int SQRT_ITERS = N2_W;
    localparam int DIV_SHIFT  = 46;
    localparam int DIV_W      = AXIS_W + DIV_SHIFT;
    localparam int DIV_ITERS  = DIV_W;
    localparam int CNT_W      = $clog2(DIV_ITERS);
    localparam int STEP_W     = $clog2(CORDIC_STEPS);
    localparam int MUL_OPS    = 15;
    localparam int OP_W       = 4;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic signed [Q_W-1:0] CORDIC_KINV = Q_W'(652032874);
    localparam logic signed [Q_W-1:0] ONE_Q30     = Q_W'(1) <<< Q_FRAC;

    typedef enum logic [1:0] {
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z,
        REG_TURN_ANGLE
    } t_reg_idx;

    typedef logic [8:0][COEF_WIDTH-1:0] t_matrix;

    typedef struct packed {
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
        logic [ANGLE_W-1:0]       turn_angle;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic zero_axis;
    } t_coef_status;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] cos_v;
        logic signed [Q_W-1:0] sin_v;
    } t_cordic_res;

    // Arctangent of 2^-i, 2^32 units per turn
    function automatic logic signed [Q_W-1:0] atan_unit(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_unit = Q_W'(536870912);
            5'd1:    atan_unit = Q_W'(316933406);
            5'd2:    atan_unit = Q_W'(167458907);
            5'd3:    atan_unit = Q_W'(85004756);
            5'd4:    atan_unit = Q_W'(42667331);
            5'd5:    atan_unit = Q_W'(21354465);
            5'd6:    atan_unit = Q_W'(10679838);
            5'd7:    atan_unit = Q_W'(5340245);
            5'd8:    atan_unit = Q_W'(2670163);
            5'd9:    atan_unit = Q_W'(1335087);
            5'd10:   atan_unit = Q_W'(667544);
            5'd11:   atan_unit = Q_W'(333772);
            5'd12:   atan_unit = Q_W'(166886);
            5'd13:   atan_unit = Q_W'(83443);
            5'd14:   atan_unit = Q_W'(41722);
            5'd15:   atan_unit = Q_W'(20861);
            5'd16:   atan_unit = Q_W'(10430);
            5'd17:   atan_unit = Q_W'(5215);
            5'd18:   atan_unit = Q_W'(2608);
            5'd19:   atan_unit = Q_W'(1304);
            5'd20:   atan_unit = Q_W'(652);
            5'd21:   atan_unit = Q_W'(326);
            5'd22:   atan_unit = Q_W'(163);
            5'd23:   atan_unit = Q_W'(81);
            5'd24:   atan_unit = Q_W'(41);
            5'd25:   atan_unit = Q_W'(20);
            5'd26:   atan_unit = Q_W'(10);
            5'd27:   atan_unit = Q_W'(5);
            5'd28:   atan_unit = Q_W'(3);
            5'd29:   atan_unit = Q_W'(1);
            default: atan_unit = '0;
        endcase
    endfunction

endpackage

### rtl/aav_cordic.sv
// ----------------------------------------------------------------------------
// aav_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then a
// quarter-turn fold gives cosine and sine in Q30.
// ----------------------------------------------------------------------------
module aav_cordic
    import aav_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ANGLE_W-1:0] i_angle,
    output t_cordic_res        o_res
);

    logic                  r_run;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [1:0]            r_quad;
    logic signed [Q_W-1:0] r_cx;
    logic signed [Q_W-1:0] r_sy;
    logic signed [Q_W-1:0] r_t;

    logic [ANGLE_W-1:0]    ang_bias;
    logic [1:0]            quad_in;
    logic [ANGLE_W-1:0]    resid;
    logic signed [Q_W-1:0] t_init;
    logic signed [Q_W-1:0] dx;
    logic signed [Q_W-1:0] dy;
    logic signed [Q_W-1:0] atan_v;
    logic                  last;

    // Split the angle into a quadrant and a residual of at most an eighth turn
    always_comb begin
        ang_bias = i_angle + ANGLE_W'(2 ** (ANGLE_W - 3));
        quad_in  = ang_bias[ANGLE_W-1 -: 2];
        resid    = i_angle - {quad_in, (ANGLE_W - 2)'(0)};
        t_init   = Q_W'($signed({resid, 16'h0000}));
        dx       = r_sy >>> r_step;
        dy       = r_cx >>> r_step;
        atan_v   = atan_unit(5'(r_step));
        last     = (r_step == STEP_W'(CORDIC_STEPS - 1));
    end

    // Sequence the micro-rotations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Rotate toward the residual angle, steering on its sign
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cx   <= CORDIC_KINV;
            r_sy   <= '0;
            r_t    <= t_init;
            r_quad <= quad_in;
        end else if (r_run) begin
            if (!r_t[Q_W-1]) begin
                r_cx <= r_cx - dx;
                r_sy <= r_sy + dy;
                r_t  <= r_t - atan_v;
            end else begin
                r_cx <= r_cx + dx;
                r_sy <= r_sy - dy;
                r_t  <= r_t + atan_v;
            end
        end
    end

    // Fold back by whole quarter turns
    always_comb begin
        o_res.done = r_done;
        case (r_quad)
            2'd0: begin
                o_res.cos_v = r_cx;
                o_res.sin_v = r_sy;
            end
            2'd1: begin
                o_res.cos_v = -r_sy;
                o_res.sin_v = r_cx;
            end
            2'd2: begin
                o_res.cos_v = -r_cx;
                o_res.sin_v = -r_sy;
            end
            default: begin
                o_res.cos_v = r_sy;
                o_res.sin_v = -r_cx;
            end
        endcase
    end

endmodule

### rtl/aav_coef_gen.sv
// ----------------------------------------------------------------------------
// aav_coef_gen
// Builds the cached rotation matrix: axis length by digit-serial square root,
// unit axis by a shared restoring divider, cosine/sine by CORDIC, and the
// Rodrigues terms through one shared multiplier.
// ----------------------------------------------------------------------------
module aav_coef_gen
    import aav_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_cfg_wr,
    output t_matrix      o_matrix,
    output t_coef_status o_status
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQUARE = 7'b0000010,
        ST_SQRT   = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_CORDIC = 7'b0010000,
        ST_MUL    = 7'b0100000,
        ST_BUILD  = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        COMP_X,
        COMP_Y,
        COMP_Z
    } t_comp;

    typedef enum logic [2:0] {
        SRC_UX,
        SRC_UY,
        SRC_UZ,
        SRC_OMC,
        SRC_SIN,
        SRC_TMP
    } t_src;

    typedef enum logic [3:0] {
        DST_TMP,
        DST_XX,
        DST_YY,
        DST_ZZ,
        DST_XY,
        DST_XZ,
        DST_YZ,
        DST_ZS,
        DST_YS,
        DST_XS
    } t_dst;

    typedef struct packed {
        t_src a;
        t_src b;
        t_dst d;
    } t_mul_op;

    localparam logic signed [Q_W-1:0] C_MAX = Q_W'(2 ** (COEF_WIDTH - 1) - 1);
    localparam logic signed [Q_W-1:0] C_MIN = -C_MAX - Q_W'(1);
    localparam logic signed [Q_W-1:0] C_RND = Q_W'(COEF_RND);

    // Product schedule: squares and cross terms times (1 - cos), axis times sin
    function automatic t_mul_op mul_op(input logic [OP_W-1:0] idx);
        case (idx)
            4'd0:    mul_op = '{SRC_UX,  SRC_UX,  DST_TMP};
            4'd1:    mul_op = '{SRC_TMP, SRC_OMC, DST_XX};
            4'd2:    mul_op = '{SRC_UY,  SRC_UY,  DST_TMP};
            4'd3:    mul_op = '{SRC_TMP, SRC_OMC, DST_YY};
            4'd4:    mul_op = '{SRC_UZ,  SRC_UZ,  DST_TMP};
            4'd5:    mul_op = '{SRC_TMP, SRC_OMC, DST_ZZ};
            4'd6:    mul_op = '{SRC_UX,  SRC_UY,  DST_TMP};
            4'd7:    mul_op = '{SRC_TMP, SRC_OMC, DST_XY};
            4'd8:    mul_op = '{SRC_UX,  SRC_UZ,  DST_TMP};
            4'd9:    mul_op = '{SRC_TMP, SRC_OMC, DST_XZ};
            4'd10:   mul_op = '{SRC_UY,  SRC_UZ,  DST_TMP};
            4'd11:   mul_op = '{SRC_TMP, SRC_OMC, DST_YZ};
            4'd12:   mul_op = '{SRC_UZ,  SRC_SIN, DST_ZS};
            4'd13:   mul_op = '{SRC_UY,  SRC_SIN, DST_YS};
            default: mul_op = '{SRC_UX,  SRC_SIN, DST_XS};
        endcase
    endfunction

    // Round a Q30 value to the coefficient grid and clamp it
    function automatic logic [COEF_WIDTH-1:0] to_coef(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] r;
        r = (v + C_RND) >>> COEF_SH;
        if (r > C_MAX) begin
            r = C_MAX;
        end else if (r < C_MIN) begin
            r = C_MIN;
        end
        to_coef = r[COEF_WIDTH-1:0];
    endfunction

    function automatic logic [AXIS_W-1:0] comp_mag(input logic signed [AXIS_W-1:0] a);
        comp_mag = a[AXIS_W-1] ? AXIS_W'(-a) : AXIS_W'(a);
    endfunction

    // Control state
    t_state             r_state, n_state;
    logic               r_dirty, n_dirty;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_comp              r_comp, n_comp;
    logic               r_phase, n_phase;
    logic               r_zero;
    logic               cordic_start;
    t_cordic_res        cordic_res;

    // Datapath registers
    logic [2*N2_W-1:0]       r_rad;
    logic [N2_W+1:0]         r_rem;
    logic [N2_W-1:0]         r_root;
    logic [DIV_W-1:0]        r_dvd;
    logic [N2_W-1:0]         r_drem;
    logic [Q_W-1:0]          r_quo;
    logic                    r_zero_pend;
    logic signed [Q_W-1:0]   r_ux, r_uy, r_uz;
    logic signed [Q_W-1:0]   r_cos, r_sin, r_omc;
    logic signed [2*Q_W-1:0] r_prod;
    logic signed [Q_W-1:0]   r_tmp;
    logic signed [Q_W-1:0]   r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    logic signed [Q_W-1:0]   r_pzs, r_pys, r_pxs;
    t_matrix                 r_matrix;

    // Combinational helpers
    logic signed [N2_W-1:0]  sq_x, sq_y, sq_z;
    logic [N2_W-1:0]         n2;
    logic [N2_W+3:0]         rem_t, trial, rem_n;
    logic                    rt_ge;
    logic [N2_W:0]           dr_t;
    logic                    dv_ge;
    logic [N2_W-1:0]         drem_n;
    logic [Q_W-1:0]          quo_n;
    logic signed [AXIS_W-1:0] comp_cur, comp_nxt;
    logic signed [Q_W-1:0]   u_val;
    t_mul_op                 op;
    logic signed [Q_W-1:0]   opa, opb, wb;
    logic signed [Q_W-1:0]   m [9];
    logic                    sqrt_last, div_last, mul_last;

    aav_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (i_cfg.turn_angle),
        .o_res   (cordic_res)
    );

    // Squared axis length
    always_comb begin
        sq_x = $signed(i_cfg.axis_x) * $signed(i_cfg.axis_x);
        sq_y = $signed(i_cfg.axis_y) * $signed(i_cfg.axis_y);
        sq_z = $signed(i_cfg.axis_z) * $signed(i_cfg.axis_z);
        n2   = N2_W'(sq_x) + N2_W'(sq_y) + N2_W'(sq_z);
    end

    // Square root step: two radicand bits in, one root bit out
    always_comb begin
        rem_t  = {r_rem, r_rad[2*N2_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        rt_ge  = (rem_t >= trial);
        rem_n  = rt_ge ? (rem_t - trial) : rem_t;
    end

    // Division step: one quotient bit
    always_comb begin
        dr_t   = {r_drem, r_dvd[DIV_W-1]};
        dv_ge  = (dr_t >= {1'b0, r_root});
        drem_n = dv_ge ? N2_W'(dr_t - {1'b0, r_root}) : N2_W'(dr_t);
        quo_n  = {r_quo[Q_W-2:0], dv_ge};
    end

    // Pick axis components for the divider
    always_comb begin
        unique case (r_comp)
            COMP_X:  comp_cur = i_cfg.axis_x;
            COMP_Y:  comp_cur = i_cfg.axis_y;
            default: comp_cur = i_cfg.axis_z;
        endcase
        unique case (n_comp)
            COMP_X:  comp_nxt = i_cfg.axis_x;
            COMP_Y:  comp_nxt = i_cfg.axis_y;
            default: comp_nxt = i_cfg.axis_z;
        endcase
        u_val = comp_cur[AXIS_W-1] ? -$signed(quo_n) : $signed(quo_n);
    end

    // Shared multiplier operands and write-back value
    always_comb begin
        op = mul_op(r_cnt[OP_W-1:0]);
        case (op.a)
            SRC_UX:  opa = r_ux;
            SRC_UY:  opa = r_uy;
            SRC_UZ:  opa = r_uz;
            SRC_OMC: opa = r_omc;
            SRC_SIN: opa = r_sin;
            default: opa = r_tmp;
        endcase
        case (op.b)
            SRC_UX:  opb = r_ux;
            SRC_UY:  opb = r_uy;
            SRC_UZ:  opb = r_uz;
            SRC_OMC: opb = r_omc;
            SRC_SIN: opb = r_sin;
            default: opb = r_tmp;
        endcase
        wb = Q_W'(r_prod >>> Q_FRAC);
    end

    // Rodrigues matrix terms, row major
    always_comb begin
        m[0] = r_cos + r_pxx;
        m[1] = r_pxy - r_pzs;
        m[2] = r_pxz + r_pys;
        m[3] = r_pxy + r_pzs;
        m[4] = r_cos + r_pyy;
        m[5] = r_pyz - r_pxs;
        m[6] = r_pxz - r_pys;
        m[7] = r_pyz + r_pxs;
        m[8] = r_cos + r_pzz;
    end

    always_comb begin
        sqrt_last = (r_cnt == CNT_W'(SQRT_ITERS - 1));
        div_last  = (r_cnt == CNT_W'(DIV_ITERS - 1));
        mul_last  = (r_cnt == CNT_W'(MUL_OPS - 1));
    end

    // Sequence the rebuild
    always_comb begin
        n_state      = r_state;
        n_dirty      = r_dirty;
        n_cnt        = r_cnt;
        n_comp       = r_comp;
        n_phase      = r_phase;
        cordic_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (r_dirty) begin
                    n_state = ST_SQUARE;
                    n_dirty = 1'b0;
                end
            end
            ST_SQUARE: begin
                n_cnt   = '0;
                n_state = (n2 == '0) ? ST_BUILD : ST_SQRT;
            end
            ST_SQRT: begin
                if (sqrt_last) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                    n_comp  = COMP_X;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    n_cnt = '0;
                    if (r_comp == COMP_Z) begin
                        n_state      = ST_CORDIC;
                        cordic_start = 1'b1;
                    end else begin
                        n_comp = (r_comp == COMP_X) ? COMP_Y : COMP_Z;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CORDIC: begin
                if (cordic_res.done) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                    n_phase = 1'b0;
                end
            end
            ST_MUL: begin
                n_phase = ~r_phase;
                if (r_phase) begin
                    if (mul_last) begin
                        n_state = ST_BUILD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_BUILD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // A register write always forces another rebuild
        if (i_cfg_wr) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dirty <= 1'b1;
            r_cnt   <= '0;
            r_comp  <= COMP_X;
            r_phase <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
            r_phase <= n_phase;
            if (r_state == ST_BUILD) begin
                r_zero <= r_zero_pend;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_SQUARE: begin
                r_zero_pend <= (n2 == '0);
                r_rad       <= {n2, N2_W'(0)};
                r_rem       <= '0;
                r_root      <= '0;
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[2*N2_W-3:0], 2'b00};
                r_rem  <= (N2_W + 2)'(rem_n);
                r_root <= {r_root[N2_W-2:0], rt_ge};
                if (sqrt_last) begin
                    r_dvd  <= {comp_mag(comp_nxt), DIV_SHIFT'(0)};
                    r_drem <= '0;
                    r_quo  <= '0;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    unique case (r_comp)
                        COMP_X:  r_ux <= u_val;
                        COMP_Y:  r_uy <= u_val;
                        default: r_uz <= u_val;
                    endcase
                    r_dvd  <= {comp_mag(comp_nxt), DIV_SHIFT'(0)};
                    r_drem <= '0;
                    r_quo  <= '0;
                end else begin
                    r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
                    r_drem <= drem_n;
                    r_quo  <= quo_n;
                end
            end
            ST_CORDIC: begin
                if (cordic_res.done) begin
                    r_cos <= cordic_res.cos_v;
                    r_sin <= cordic_res.sin_v;
                    r_omc <= ONE_Q30 - cordic_res.cos_v;
                end
            end
            ST_MUL: begin
                if (!r_phase) begin
                    r_prod <= opa * opb;
                end else begin
                    case (op.d)
                        DST_TMP: r_tmp <= wb;
                        DST_XX:  r_pxx <= wb;
                        DST_YY:  r_pyy <= wb;
                        DST_ZZ:  r_pzz <= wb;
                        DST_XY:  r_pxy <= wb;
                        DST_XZ:  r_pxz <= wb;
                        DST_YZ:  r_pyz <= wb;
                        DST_ZS:  r_pzs <= wb;
                        DST_YS:  r_pys <= wb;
                        default: r_pxs <= wb;
                    endcase
                end
            end
            ST_BUILD: begin
                for (int k = 0; k < 9; k++) begin
                    r_matrix[k] <= r_zero_pend ? '0 : to_coef(m[k]);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_matrix           = r_matrix;
    assign o_status.busy      = (r_state != ST_IDLE) || r_dirty;
    assign o_status.zero_axis = r_zero;

endmodule

### rtl/aav_vec_pipe.sv
// ----------------------------------------------------------------------------
// aav_vec_pipe
// Three-stage matrix-vector product: nine products, row sums, then rounding
// and saturation into the output register. Each stage moves on when the
// stage after it is empty or moving.
// ----------------------------------------------------------------------------
module aav_vec_pipe
    import aav_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [VEC_WIDTH-1:0] i_vec_x,
    input  logic signed [VEC_WIDTH-1:0] i_vec_y,
    input  logic signed [VEC_WIDTH-1:0] i_vec_z,
    input  logic                        i_hold,
    input  t_matrix                     i_matrix,
    input  logic                        i_zero,
    input  logic                        i_stall,
    output logic                        o_stall,
    output logic                        o_valid,
    output logic signed [VEC_WIDTH-1:0] o_rot_x,
    output logic signed [VEC_WIDTH-1:0] o_rot_y,
    output logic signed [VEC_WIDTH-1:0] o_rot_z,
    output logic                        o_clipped,
    output logic                        o_zero_axis
);

    localparam logic signed [SUM_W-1:0] S_RND = SUM_W'(2 ** (COEF_FRAC - 1));
    localparam logic signed [RES_W-1:0] V_MAX = (RES_W'(1) <<< (VEC_WIDTH - 1)) - RES_W'(1);
    localparam logic signed [RES_W-1:0] V_MIN = -V_MAX - RES_W'(1);

    logic r_v1, r_v2, r_v3;
    logic r_z1, r_z2;
    logic en1, en2, en3;
    logic accept;

    logic signed [VEC_WIDTH-1:0] vin [3];
    logic signed [PROD_W-1:0]    n_prod [9];
    logic signed [PROD_W-1:0]    r_prod [9];
    logic signed [SUM_W-1:0]     n_sum [3];
    logic signed [SUM_W-1:0]     r_sum [3];
    logic signed [RES_W-1:0]     rnd [3];
    logic signed [VEC_WIDTH-1:0] sat [3];
    logic [2:0]                  clip;

    // Stage enables
    always_comb begin
        en3     = !r_v3 || !i_stall;
        en2     = !r_v2 || en3;
        en1     = !r_v1 || en2;
        o_stall = i_hold || !en1;
        accept  = i_valid && !o_stall;
    end

    // Products of each coefficient with its vector component, and the row sums with the rounding offset
    always_comb begin
        vin[0] = i_vec_x;
        vin[1] = i_vec_y;
        vin[2] = i_vec_z;
        for (int k = 0; k < 9; k++) begin
            n_prod[k] = $signed(i_matrix[k]) * vin[k % 3];
        end
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = SUM_W'(r_prod[3*r]) + SUM_W'(r_prod[3*r+1])
                     + SUM_W'(r_prod[3*r+2]) + S_RND;
        end
    end

    // Round half up and clamp each row
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rnd[r] = RES_W'(r_sum[r] >>> COEF_FRAC);
            if (rnd[r] > V_MAX) begin
                sat[r]  = V_MAX[VEC_WIDTH-1:0];
                clip[r] = 1'b1;
            end else if (rnd[r] < V_MIN) begin
                sat[r]  = V_MIN[VEC_WIDTH-1:0];
                clip[r] = 1'b1;
            end else begin
                sat[r]  = rnd[r][VEC_WIDTH-1:0];
                clip[r] = 1'b0;
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_prod <= n_prod;
            r_z1   <= i_zero;
        end
        if (en2) begin
            r_sum <= n_sum;
            r_z2  <= r_z1;
        end
        if (en3) begin
            o_rot_x     <= sat[0];
            o_rot_y     <= sat[1];
            o_rot_z     <= sat[2];
            o_clipped   <= |clip;
            o_zero_axis <= r_z2;
        end
    end

    assign o_valid = r_v3;

endmodule

### rtl/axis_angle_vector_rotator_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotator_unit
// Rotates Q16.16 vectors about a programmable axis by a programmable angle.
// ----------------------------------------------------------------------------
// Vectors stream in at one per cycle while o_stall is low and pass through the
// product, row-sum and output registers; the rate is set by the nine parallel
// 18x32 multipliers of the product pipeline. After reset and after every
// register write the rotation matrix is rebuilt while o_stall is held high,
// mostly in the bit-serial divider that normalizes the three axis components,
// plus a square root, a 16-step CORDIC and 15 shared multiplies. An axis
// of (0,0,0) yields a zero matrix and raises o_zero_axis on every result.
module axis_angle_vector_rotator_unit
    import aav_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [PDATA_W-1:0]          pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [VEC_WIDTH-1:0] i_vec_x,
    input  logic signed [VEC_WIDTH-1:0] i_vec_y,
    input  logic signed [VEC_WIDTH-1:0] i_vec_z,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [VEC_WIDTH-1:0] o_rot_x,
    output logic signed [VEC_WIDTH-1:0] o_rot_y,
    output logic signed [VEC_WIDTH-1:0] o_rot_z,
    output logic                        o_clipped,
    output logic                        o_zero_axis
);

    t_cfg         r_cfg;
    t_reg_idx     reg_idx;
    logic         cfg_wr;
    t_matrix      matrix;
    t_coef_status status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_x     <= '0;
            r_cfg.axis_y     <= '0;
            r_cfg.axis_z     <= AXIS_W'(1);
            r_cfg.turn_angle <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_AXIS_X:     r_cfg.axis_x     <= pwdata[AXIS_W-1:0];
                REG_AXIS_Y:     r_cfg.axis_y     <= pwdata[AXIS_W-1:0];
                REG_AXIS_Z:     r_cfg.axis_z     <= pwdata[AXIS_W-1:0];
                REG_TURN_ANGLE: r_cfg.turn_angle <= pwdata[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_AXIS_X:     prdata = PDATA_W'(r_cfg.axis_x);
            REG_AXIS_Y:     prdata = PDATA_W'(r_cfg.axis_y);
            REG_AXIS_Z:     prdata = PDATA_W'(r_cfg.axis_z);
            REG_TURN_ANGLE: prdata = PDATA_W'(r_cfg.turn_angle);
            default:        prdata = '0;
        endcase
    end

    aav_coef_gen u_coef_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_wr (cfg_wr),
        .o_matrix (matrix),
        .o_status (status)
    );

    aav_vec_pipe u_vec_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_hold      (status.busy || cfg_wr),
        .i_matrix    (matrix),
        .i_zero      (status.zero_axis),
        .i_stall     (i_stall),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z),
        .o_clipped   (o_clipped),
        .o_zero_axis (o_zero_axis)
    );

endmodule

### rtl/aav_checker.sv
// ----------------------------------------------------------------------------
// aav_checker
// Port-level checks of the rotator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module aav_checker
    import aav_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic                        i_stall,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic signed [VEC_WIDTH-1:0] o_rot_x,
    input logic signed [VEC_WIDTH-1:0] o_rot_y,
    input logic signed [VEC_WIDTH-1:0] o_rot_z,
    input logic                        o_clipped,
    input logic                        o_zero_axis
);

    localparam logic signed [VEC_WIDTH-1:0] V_MAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] V_MIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

    // Hold a stalled result
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rot_x) && $stable(o_rot_y)
                               && $stable(o_rot_z) && $stable(o_clipped))
        else $error("stalled result changed");

    // Zero axis gives a zero, unclipped result
    a_zero_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_axis |-> o_rot_x == '0 && o_rot_y == '0 && o_rot_z == '0
                                   && !o_clipped)
        else $error("zero axis result not zero");

    // A clipped result shows a rail value
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> o_rot_x == V_MAX || o_rot_x == V_MIN
                                 || o_rot_y == V_MAX || o_rot_y == V_MIN
                                 || o_rot_z == V_MAX || o_rot_z == V_MIN)
        else $error("clip flag without saturated component");

    // A register write blocks requests now and while its rebuild is still pending
    a_write_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |-> o_stall ##1 o_stall)
        else $error("request taken during matrix rebuild");

endmodule

bind axis_angle_vector_rotator_unit aav_checker u_aav_checker (.*);
